@@ sv/duffing_rkf45_step_assert.svh @@
// Assertion helpers for the Duffing step block.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef DUFFING_RKF45_STEP_ASSERT_SVH
`define DUFFING_RKF45_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/drk_pkg.sv @@
`timescale 1ns / 1ps
package drk_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_W       = 24;
  localparam int CSHIFT       = 30;
  localparam int CORDIC_ITERS = 16;
  localparam int CITER_W      = $clog2(CORDIC_ITERS);
  localparam int COEF_W       = 36;
  localparam int OPB_W        = WORD_W + 1;
  localparam int PROD_W       = COEF_W + OPB_W;
  localparam int ACC_W        = 72;
  localparam int CORD_W       = 64;
  localparam int CORD_FRAC    = 61;
  localparam int Z_W          = 34;
  localparam int CFG_IDX_W    = 3;

  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 64'sd1400229935014726496;
  localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PPS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IPOS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IVEL  = 3'd5;

  localparam logic [30:0]              STEP_RST = 31'd413389;
  localparam logic signed [WORD_W-1:0] DAMP_RST = 32'sd4026532;
  localparam logic signed [WORD_W-1:0] FAMP_RST = 32'sd11408507;
  localparam logic [31:0]              PPS_RST  = 32'd28633115;
  localparam logic signed [WORD_W-1:0] IPOS_RST = 32'sd16777216;
  localparam logic signed [WORD_W-1:0] IVEL_RST = -32'sd16777216;

  // Stage four drive phase is round(12/13 of the phase advance). The quotient
  // by 13 of any 32-bit value is its product with this constant shifted right by 34.
  localparam logic [31:0] RECIP13 = 32'h4EC4_EC4F;

  // Tableau coefficients, rounded half up to 30 fraction bits.
  localparam longint P31 = 64'sd2147483648;
  localparam longint CF_1_4         = (1 * P31 + 4) / 8;
  localparam longint CF_3_32        = (3 * P31 + 32) / 64;
  localparam longint CF_9_32        = (9 * P31 + 32) / 64;
  localparam longint CF_1932_2197   = (1932 * P31 + 2197) / 4394;
  localparam longint CF_7200_2197   = (7200 * P31 + 2197) / 4394;
  localparam longint CF_7296_2197   = (7296 * P31 + 2197) / 4394;
  localparam longint CF_439_216     = (439 * P31 + 216) / 432;
  localparam longint CF_8_1         = (8 * P31 + 1) / 2;
  localparam longint CF_3680_513    = (3680 * P31 + 513) / 1026;
  localparam longint CF_845_4104    = (845 * P31 + 4104) / 8208;
  localparam longint CF_8_27        = (8 * P31 + 27) / 54;
  localparam longint CF_2_1         = (2 * P31 + 1) / 2;
  localparam longint CF_3544_2565   = (3544 * P31 + 2565) / 5130;
  localparam longint CF_1859_4104   = (1859 * P31 + 4104) / 8208;
  localparam longint CF_11_40       = (11 * P31 + 40) / 80;
  localparam longint CF_16_135      = (16 * P31 + 135) / 270;
  localparam longint CF_6656_12825  = (6656 * P31 + 12825) / 25650;
  localparam longint CF_28561_56430 = (28561 * P31 + 56430) / 112860;
  localparam longint CF_9_50        = (9 * P31 + 50) / 100;
  localparam longint CF_2_55        = (2 * P31 + 55) / 110;
  localparam longint CF_1_360       = (1 * P31 + 360) / 720;
  localparam longint CF_128_4275    = (128 * P31 + 4275) / 8550;
  localparam longint CF_2197_75240  = (2197 * P31 + 75240) / 150480;
  localparam longint CF_1_50        = (1 * P31 + 50) / 100;

  typedef struct packed {
    logic load;
    logic issue;
    logic shift30;
  } mac_cmd_t;

  // Rows 0..4 build the stage inputs, row 5 the new state, row 6 the error.
  function automatic logic signed [COEF_W-1:0] tab_coef(input logic [2:0] row,
                                                         input logic [2:0] col);
    longint v;
    v = 0;
    case ({row, col})
      6'o00: v = CF_1_4;
      6'o10: v = CF_3_32;
      6'o11: v = CF_9_32;
      6'o20: v = CF_1932_2197;
      6'o21: v = -CF_7200_2197;
      6'o22: v = CF_7296_2197;
      6'o30: v = CF_439_216;
      6'o31: v = -CF_8_1;
      6'o32: v = CF_3680_513;
      6'o33: v = -CF_845_4104;
      6'o40: v = -CF_8_27;
      6'o41: v = CF_2_1;
      6'o42: v = -CF_3544_2565;
      6'o43: v = CF_1859_4104;
      6'o44: v = -CF_11_40;
      6'o50: v = CF_16_135;
      6'o52: v = CF_6656_12825;
      6'o53: v = CF_28561_56430;
      6'o54: v = -CF_9_50;
      6'o55: v = CF_2_55;
      6'o60: v = CF_1_360;
      6'o62: v = -CF_128_4275;
      6'o63: v = -CF_2197_75240;
      6'o64: v = CF_1_50;
      6'o65: v = CF_2_55;
      default: v = 0;
    endcase
    return COEF_W'(v);
  endfunction

  // Arctangent of 2^-i in 2^-32 turns.
  function automatic logic signed [Z_W-1:0] atan_coef(input logic [4:0] idx);
    longint v;
    v = 0;
    case (idx)
      5'd0:  v = 536870912;
      5'd1:  v = 316933406;
      5'd2:  v = 167458907;
      5'd3:  v = 85004756;
      5'd4:  v = 42667331;
      5'd5:  v = 21354465;
      5'd6:  v = 10679838;
      5'd7:  v = 5340245;
      5'd8:  v = 2670163;
      5'd9:  v = 1335087;
      5'd10: v = 667544;
      5'd11: v = 333772;
      5'd12: v = 166886;
      5'd13: v = 83443;
      5'd14: v = 41722;
      5'd15: v = 20861;
      5'd16: v = 10430;
      5'd17: v = 5215;
      5'd18: v = 2608;
      5'd19: v = 1304;
      5'd20: v = 652;
      5'd21: v = 326;
      5'd22: v = 163;
      5'd23: v = 81;
      5'd24: v = 41;
      5'd25: v = 20;
      5'd26: v = 10;
      5'd27: v = 5;
      5'd28: v = 3;
      5'd29: v = 1;
      5'd30: v = 1;
      default: v = 0;
    endcase
    return Z_W'(v);
  endfunction

endpackage

@@ sv/drk_mac.sv @@
`timescale 1ns / 1ps
module drk_mac import drk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_cmd_t                 cmd_i,
  input  logic signed [ACC_W-1:0]  load_i,
  input  logic signed [COEF_W-1:0] a_i,
  input  logic signed [OPB_W-1:0]  b_i,
  output logic signed [WORD_W-1:0] res_o,
  output logic                     sat_o
);

  localparam logic signed [ACC_W-1:0] HALF_30 = ACC_W'(1) <<< (CSHIFT - 1);
  localparam logic signed [ACC_W-1:0] HALF_24 = ACC_W'(1) <<< (FRAC_W - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic                     fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.issue;
    end
  end

  // The product is registered on issue and added to the accumulator in the next cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q <= a_i * b_i;
    end
    if (cmd_i.load) begin
      acc_q <= load_i;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  always_comb begin
    if (cmd_i.shift30) begin
      rnd = (acc_q + HALF_30) >>> CSHIFT;
    end else begin
      rnd = (acc_q + HALF_24) >>> FRAC_W;
    end
    fits  = (rnd[ACC_W-1:WORD_W-1] == '0) || (rnd[ACC_W-1:WORD_W-1] == '1);
    sat_o = !fits;
    if (fits) begin
      res_o = rnd[WORD_W-1:0];
    end else if (rnd[ACC_W-1]) begin
      res_o = WMIN;
    end else begin
      res_o = WMAX;
    end
  end

endmodule

@@ sv/drk_cordic.sv @@
`timescale 1ns / 1ps
module drk_cordic import drk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              phase_i,
  output logic                     done_o,
  output logic signed [WORD_W-1:0] cos_o,
  output logic                     sat_o
);

  localparam int RSH = CORD_FRAC - FRAC_W;
  localparam logic signed [CORD_W:0] HALF = (CORD_W + 1)'(1) <<< (RSH - 1);

  logic                     busy_q, done_q, neg_q;
  logic [CITER_W-1:0]       iter_q;
  logic signed [CORD_W-1:0] x_q, y_q, xs, ys;
  logic signed [Z_W-1:0]    z_q, at;
  logic [31:0]              fold;
  logic signed [CORD_W:0]   xr;
  logic signed [WORD_W-1:0] c;
  logic                     c_sat;

  // Shift by a quarter turn; phases from a quarter to three quarters of a turn flip the sign.
  assign fold = phase_i + PHASE_QUARTER;
  assign xs   = x_q >>> iter_q;
  assign ys   = y_q >>> iter_q;
  assign at   = atan_coef(5'(iter_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        if (iter_q == CITER_W'(CORDIC_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= fold[31];
      x_q   <= CORDIC_GAIN;
      y_q   <= '0;
      z_q   <= Z_W'(signed'({phase_i[31] ^ fold[31], phase_i[30:0]}));
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    xr    = ((CORD_W + 1)'(x_q) + HALF) >>> RSH;
    c_sat = !((xr[CORD_W:WORD_W-1] == '0) || (xr[CORD_W:WORD_W-1] == '1));
    if (!c_sat) begin
      c = xr[WORD_W-1:0];
    end else if (xr[CORD_W]) begin
      c = WMIN;
    end else begin
      c = WMAX;
    end
    sat_o = c_sat;
    cos_o = c;
    if (neg_q) begin
      if (c == WMIN) begin
        cos_o = WMAX;
        sat_o = 1'b1;
      end else begin
        cos_o = -c;
      end
    end
  end

  assign done_o = done_q;

endmodule

@@ sv/duffing_rkf45_step.sv @@
`timescale 1ns / 1ps
// A beat is taken only while idle: a new beat waits until the previous step has
// registered its result, which waits while an earlier result is held by a stall.
// One multiply-accumulate unit (one product per cycle, product and accumulator
// registered) runs 38 jobs per step, the 16-iteration CORDIC runs six times, and
// a reciprocal multiply gives the stage four phase offset first.
// Reset restores only the control, configuration and oscillator state registers.
`include "duffing_rkf45_step_assert.svh"
module duffing_rkf45_step import drk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     restart_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] position_o,
  output logic signed [WORD_W-1:0] velocity_o,
  output logic [31:0]              drive_phase_o,
  output logic [30:0]              error_estimate_o,
  output logic                     saturated_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV      = 9'b000000010,
    S_COS_GO   = 9'b000000100,
    S_COS_WAIT = 9'b000001000,
    S_LOAD     = 9'b000010000,
    S_MAC      = 9'b000100000,
    S_DRAIN    = 9'b001000000,
    S_WB       = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_e;

  typedef enum logic [3:0] {
    J_C0, J_C1, J_COS, J_P2, J_AC, J_H0, J_H1, J_E0, J_E1, J_F0, J_F1
  } job_e;

  state_e state_q;
  job_e   job_q;
  logic [2:0] stage_q, term_q, n_terms;
  logic       div_cnt_q;
  logic [31:0] dq_q;
  logic [63:0] recip_q;
  logic [29:0] quo;
  logic [31:0] rem_full, dq_next;

  logic [30:0]              step_q;
  logic signed [WORD_W-1:0] damp_q, famp_q, ipos_q, ivel_q;
  logic [31:0]              pps_q;

  logic signed [WORD_W-1:0] pos_q, vel_q, p_q, v_q, cv_q, p2_q, a_q;
  logic [31:0]              phase_q;
  logic signed [WORD_W-1:0] hk_q [6][2];
  logic [WORD_W-1:0]        e0_q, e1_q;
  logic                     sat_q, out_valid_q;

  logic signed [WORD_W-1:0] pos_out_q, vel_out_q;
  logic [31:0]              phase_out_q;
  logic [30:0]              err_out_q;
  logic                     sat_out_q;

  mac_cmd_t                 mac_cmd;
  logic signed [ACC_W-1:0]  mac_load;
  logic signed [COEF_W-1:0] mac_a;
  logic signed [OPB_W-1:0]  mac_b;
  logic signed [WORD_W-1:0] mac_res;
  logic                     mac_sat;

  logic                     cos_done, cos_sat;
  logic signed [WORD_W-1:0] cos_val;
  logic [31:0]              ph_off, stage_phase;
  logic [33:0]              off_sum;

  logic                     hk_col, is_err;
  logic signed [WORD_W-1:0] hk_sel;
  logic [WORD_W-1:0]        abs_val, emax;
  logic                     abs_sat, wb_sat;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);

  // Drive phase offset of each stage within the step.
  always_comb begin
    off_sum = '0;
    ph_off  = '0;
    case (stage_q)
      3'd1: begin
        off_sum = 34'(pps_q) + 34'd2;
        ph_off  = off_sum[33:2];
      end
      3'd2: begin
        off_sum = 34'({pps_q, 1'b0}) + 34'(pps_q) + 34'd4;
        ph_off  = 32'(off_sum[33:3]);
      end
      3'd3: ph_off = dq_q;
      3'd4: ph_off = pps_q;
      3'd5: begin
        off_sum = 34'(pps_q) + 34'd1;
        ph_off  = off_sum[32:1];
      end
      default: ph_off = '0;
    endcase
    stage_phase = phase_q + ph_off;
  end

  always_comb begin
    case (job_q)
      J_C0, J_C1: n_terms = stage_q;
      J_AC:       n_terms = 3'd3;
      J_E0, J_E1, J_F0, J_F1: n_terms = 3'd6;
      default:    n_terms = 3'd1;
    endcase
  end

  // Operand selection for the current job and term.
  always_comb begin
    hk_col   = (job_q == J_C1) || (job_q == J_E1) || (job_q == J_F1);
    is_err   = (job_q == J_E0) || (job_q == J_E1);
    hk_sel   = hk_q[term_q][hk_col];
    mac_a    = '0;
    mac_b    = '0;
    mac_load = '0;
    case (job_q)
      J_C0, J_C1: begin
        mac_a = tab_coef(stage_q - 3'd1, term_q);
        mac_b = OPB_W'(hk_sel);
        mac_load = (job_q == J_C0) ? (ACC_W'(pos_q) <<< CSHIFT) : (ACC_W'(vel_q) <<< CSHIFT);
      end
      J_F0, J_F1: begin
        mac_a = tab_coef(3'd5, term_q);
        mac_b = OPB_W'(hk_sel);
        mac_load = (job_q == J_F0) ? (ACC_W'(pos_q) <<< CSHIFT) : (ACC_W'(vel_q) <<< CSHIFT);
      end
      J_E0, J_E1: begin
        mac_a = tab_coef(3'd6, term_q);
        mac_b = OPB_W'(hk_sel);
      end
      J_P2: begin
        mac_a = COEF_W'(p_q);
        mac_b = OPB_W'(p_q);
      end
      J_AC: begin
        mac_load = ACC_W'(p_q) <<< FRAC_W;
        case (term_q)
          3'd0: begin
            mac_a = COEF_W'(v_q);
            mac_b = -OPB_W'(damp_q);
          end
          3'd1: begin
            mac_a = COEF_W'(p_q);
            mac_b = -OPB_W'(p2_q);
          end
          default: begin
            mac_a = COEF_W'(cv_q);
            mac_b = OPB_W'(famp_q);
          end
        endcase
      end
      J_H0: begin
        mac_a = COEF_W'(v_q);
        mac_b = OPB_W'({1'b0, step_q});
      end
      J_H1: begin
        mac_a = COEF_W'(a_q);
        mac_b = OPB_W'({1'b0, step_q});
      end
      default: ;
    endcase
    mac_cmd.load    = (state_q == S_LOAD);
    mac_cmd.issue   = (state_q == S_LOAD) || (state_q == S_MAC);
    mac_cmd.shift30 = (job_q == J_C0) || (job_q == J_C1) || is_err ||
                      (job_q == J_F0) || (job_q == J_F1);
  end

  always_comb begin
    abs_sat = 1'b0;
    abs_val = mac_res;
    if (mac_res[WORD_W-1]) begin
      if (mac_res == WMIN) begin
        abs_val = WMAX;
        abs_sat = 1'b1;
      end else begin
        abs_val = -mac_res;
      end
    end
    wb_sat = mac_sat || (is_err && abs_sat);
    emax   = (e0_q > e1_q) ? e0_q : e1_q;
    // round(12p/13) is p - p/13, less one more when the remainder exceeds six.
    quo      = recip_q[63:34];
    rem_full = pps_q - 32'({quo, 3'b000}) - 32'({quo, 2'b00}) - 32'(quo);
    dq_next  = pps_q - 32'(quo) - 32'(rem_full > 32'd6);
  end

  drk_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .load_i (mac_load),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .res_o  (mac_res),
    .sat_o  (mac_sat)
  );

  drk_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_COS_GO),
    .phase_i (stage_phase),
    .done_o  (cos_done),
    .cos_o   (cos_val),
    .sat_o   (cos_sat)
  );

  // Sequencer, configuration registers and oscillator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_COS;
      stage_q     <= '0;
      term_q      <= '0;
      div_cnt_q   <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= STEP_RST;
      damp_q      <= DAMP_RST;
      famp_q      <= FAMP_RST;
      pps_q       <= PPS_RST;
      ipos_q      <= IPOS_RST;
      ivel_q      <= IVEL_RST;
      pos_q       <= IPOS_RST;
      vel_q       <= IVEL_RST;
      phase_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_STEP: step_q <= cfg_data_i[30:0];
          REG_DAMP: damp_q <= cfg_data_i;
          REG_FAMP: famp_q <= cfg_data_i;
          REG_PPS:  pps_q  <= cfg_data_i;
          REG_IPOS: ipos_q <= cfg_data_i;
          REG_IVEL: ivel_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sat_q     <= 1'b0;
            div_cnt_q <= 1'b0;
            state_q   <= S_DIV;
            if (restart_i) begin
              pos_q   <= ipos_q;
              vel_q   <= ivel_q;
              phase_q <= '0;
            end
          end
        end
        S_DIV: begin
          div_cnt_q <= 1'b1;
          if (div_cnt_q) begin
            stage_q <= '0;
            job_q   <= J_COS;
            state_q <= S_COS_GO;
          end
        end
        S_COS_GO: state_q <= S_COS_WAIT;
        S_COS_WAIT: begin
          if (cos_done) begin
            sat_q   <= sat_q | cos_sat;
            job_q   <= J_P2;
            term_q  <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          term_q  <= 3'd1;
          state_q <= (n_terms == 3'd1) ? S_DRAIN : S_MAC;
        end
        S_MAC: begin
          term_q <= term_q + 3'd1;
          if (term_q == n_terms - 3'd1) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: state_q <= S_WB;
        S_WB: begin
          sat_q  <= sat_q | wb_sat;
          term_q <= '0;
          case (job_q)
            J_C0: begin
              job_q   <= J_C1;
              state_q <= S_LOAD;
            end
            J_C1: begin
              job_q   <= J_COS;
              state_q <= S_COS_GO;
            end
            J_P2: begin
              job_q   <= J_AC;
              state_q <= S_LOAD;
            end
            J_AC: begin
              job_q   <= J_H0;
              state_q <= S_LOAD;
            end
            J_H0: begin
              job_q   <= J_H1;
              state_q <= S_LOAD;
            end
            J_H1: begin
              state_q <= S_LOAD;
              if (stage_q == 3'd5) begin
                job_q <= J_E0;
              end else begin
                stage_q <= stage_q + 3'd1;
                job_q   <= J_C0;
              end
            end
            J_E0: begin
              job_q   <= J_E1;
              state_q <= S_LOAD;
            end
            J_E1: begin
              job_q   <= J_F0;
              state_q <= S_LOAD;
            end
            J_F0: begin
              pos_q   <= mac_res;
              job_q   <= J_F1;
              state_q <= S_LOAD;
            end
            J_F1: begin
              vel_q   <= mac_res;
              state_q <= S_OUT;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            phase_q     <= phase_q + pps_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working values of the step and the result register.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_DIV: begin
        if (!div_cnt_q) begin
          recip_q <= 64'(pps_q) * 64'(RECIP13);
        end else begin
          dq_q <= dq_next;
          p_q  <= pos_q;
          v_q  <= vel_q;
        end
      end
      S_COS_WAIT: begin
        if (cos_done) begin
          cv_q <= cos_val;
        end
      end
      S_WB: begin
        case (job_q)
          J_C0: p_q  <= mac_res;
          J_C1: v_q  <= mac_res;
          J_P2: p2_q <= mac_res;
          J_AC: a_q  <= mac_res;
          J_H0: hk_q[stage_q][0] <= mac_res;
          J_H1: hk_q[stage_q][1] <= mac_res;
          J_E0: e0_q <= abs_val;
          J_E1: e1_q <= abs_val;
          default: ;
        endcase
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          pos_out_q   <= pos_q;
          vel_out_q   <= vel_q;
          phase_out_q <= phase_q + pps_q;
          err_out_q   <= emax[30:0];
          sat_out_q   <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign position_o       = pos_out_q;
  assign velocity_o       = vel_out_q;
  assign drive_phase_o    = phase_out_q;
  assign error_estimate_o = err_out_q;
  assign saturated_o      = sat_out_q;

  `DRK_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input beat taken but block not busy")
  `DRK_ASSERT_IMP(a_term_in_job, (state_q == S_LOAD) || (state_q == S_MAC), term_q < n_terms, "term index past job length")
  `DRK_ASSERT_IMP(a_stage_range, state_q != S_IDLE, stage_q <= 3'd5, "stage counter out of range")

endmodule

@@ bench/duffing_rkf45_step_test.sv @@
`timescale 1ns / 1ps
module duffing_rkf45_step_test;
  import drk_pkg::*;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [31:0]              cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     restart_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [WORD_W-1:0] position_o;
  logic signed [WORD_W-1:0] velocity_o;
  logic [31:0]              drive_phase_o;
  logic [30:0]              error_estimate_o;
  logic                     saturated_o;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] drive_phase;
    logic [30:0] error_estimate;
    logic        saturated;
  } osc_state_t;

  typedef logic signed [127:0] wide_t;

  class rkf45_scoreboard;
    longint      step_h, damp, famp, init_pos, init_vel;
    logic [31:0] phase_adv;
    longint      pos, vel;
    logic [31:0] phase;
    longint      coef [7][6];
    longint      atan_turns [16];
    longint      hk [6][2];
    int          ph_num [6];
    int          ph_den [6];
    bit          sat_seen;
    osc_state_t  expected [$];
    int          errors;

    function new();
      atan_turns = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                     83443, 41722, 20861};
      ph_num = '{0, 1, 3, 12, 1, 1};
      ph_den = '{1, 4, 8, 13, 1, 2};
      foreach (coef[r, c]) coef[r][c] = 0;
      coef[0][0] = frac(1, 4);
      coef[1][0] = frac(3, 32);       coef[1][1] = frac(9, 32);
      coef[2][0] = frac(1932, 2197);  coef[2][1] = -frac(7200, 2197);
      coef[2][2] = frac(7296, 2197);
      coef[3][0] = frac(439, 216);    coef[3][1] = -frac(8, 1);
      coef[3][2] = frac(3680, 513);   coef[3][3] = -frac(845, 4104);
      coef[4][0] = -frac(8, 27);      coef[4][1] = frac(2, 1);
      coef[4][2] = -frac(3544, 2565); coef[4][3] = frac(1859, 4104);
      coef[4][4] = -frac(11, 40);
      coef[5][0] = frac(16, 135);     coef[5][2] = frac(6656, 12825);
      coef[5][3] = frac(28561, 56430); coef[5][4] = -frac(9, 50);
      coef[5][5] = frac(2, 55);
      coef[6][0] = frac(1, 360);      coef[6][2] = -frac(128, 4275);
      coef[6][3] = -frac(2197, 75240); coef[6][4] = frac(1, 50);
      coef[6][5] = frac(2, 55);
      step_h = 413389; damp = 4026532; famp = 11408507; phase_adv = 28633115;
      init_pos = 16777216; init_vel = -16777216;
      pos = init_pos; vel = init_vel; phase = '0;
      errors = 0;
    endfunction

    // Rational coefficient rounded half up to 30 fraction bits.
    function longint frac(longint n, longint d);
      return ((n <<< 31) + d) / (2 * d);
    endfunction

    function wide_t mulw(longint a, longint b);
      wide_t pa, pb;
      pa = a;
      pb = b;
      return pa * pb;
    endfunction

    function longint clamp_word(longint v);
      if (v > 64'sd2147483647) begin
        sat_seen = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat_seen = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint round_sat(wide_t w, int sh);
      wide_t r;
      r = (w + (128'sd1 <<< (sh - 1))) >>> sh;
      if (r > 128'sd2147483647) begin
        sat_seen = 1;
        return 64'sd2147483647;
      end
      if (r < -128'sd2147483648) begin
        sat_seen = 1;
        return -64'sd2147483648;
      end
      return longint'(r);
    endfunction

    function longint drive_cos(logic [31:0] ph);
      logic [31:0] t, folded;
      bit          flip;
      longint      x, y, z, xs, ys, c;
      t = ph + 32'h4000_0000;
      flip = t[31];
      folded = t - 32'h4000_0000 - (flip ? 32'h8000_0000 : 32'h0);
      z = longint'($signed(folded));
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_turns[i];
        end else begin
          x += ys; y -= xs; z += atan_turns[i];
        end
      end
      c = round_sat(wide_t'(x), 61 - 24);
      return flip ? clamp_word(-c) : c;
    endfunction

    function void slope(logic [31:0] ph, longint p, longint v, int s);
      longint cv, p2, acc;
      wide_t  w;
      cv = drive_cos(ph);
      p2 = round_sat(mulw(p, p), 24);
      w = mulw(p, 64'sd1 <<< 24) + mulw(-damp, v) + mulw(-p2, p) + mulw(famp, cv);
      acc = round_sat(w, 24);
      hk[s][0] = round_sat(mulw(step_h, v), 24);
      hk[s][1] = round_sat(mulw(step_h, acc), 24);
    endfunction

    function longint tableau_sum(longint base, int row, int n, int c);
      wide_t w;
      w = mulw(base, 64'sd1 <<< 30);
      for (int j = 0; j < n; j++) w += mulw(coef[row][j], hk[j][c]);
      return round_sat(w, 30);
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_STEP: step_h = longint'({33'b0, d[30:0]});
        REG_DAMP: damp = longint'($signed(d));
        REG_FAMP: famp = longint'($signed(d));
        REG_PPS:  phase_adv = d;
        REG_IPOS: init_pos = longint'($signed(d));
        REG_IVEL: init_vel = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function void note_input(logic restart);
      longint      y0 [2];
      longint      ys [2];
      longint      err [2];
      longint      ev, emax;
      logic [63:0] adv;
      logic [31:0] ph;
      osc_state_t  res;
      sat_seen = 0;
      if (restart) begin
        pos = init_pos;
        vel = init_vel;
        phase = '0;
      end
      y0[0] = pos;
      y0[1] = vel;
      slope(phase, y0[0], y0[1], 0);
      for (int s = 1; s < 6; s++) begin
        adv = ({32'b0, phase_adv} * ph_num[s] + ph_den[s] / 2) / ph_den[s];
        ph = phase + adv[31:0];
        for (int c = 0; c < 2; c++) ys[c] = tableau_sum(y0[c], s - 1, s, c);
        slope(ph, ys[0], ys[1], s);
      end
      for (int c = 0; c < 2; c++) begin
        ev = tableau_sum(0, 6, 6, c);
        err[c] = ev < 0 ? clamp_word(-ev) : ev;
      end
      pos = tableau_sum(y0[0], 5, 6, 0);
      vel = tableau_sum(y0[1], 5, 6, 1);
      phase += phase_adv;
      emax = err[0] > err[1] ? err[0] : err[1];
      res.position = pos[31:0];
      res.velocity = vel[31:0];
      res.drive_phase = phase;
      res.error_estimate = emax[30:0];
      res.saturated = sat_seen;
      expected.push_back(res);
    endfunction

    function void check_result(osc_state_t got);
      osc_state_t exp_res;
      if (expected.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp_res = expected.pop_front();
      if (got.position !== exp_res.position) begin
        $error("position: expected %0d, got %0d", $signed(exp_res.position),
               $signed(got.position));
        errors++;
      end
      if (got.velocity !== exp_res.velocity) begin
        $error("velocity: expected %0d, got %0d", $signed(exp_res.velocity),
               $signed(got.velocity));
        errors++;
      end
      if (got.drive_phase !== exp_res.drive_phase) begin
        $error("drive_phase: expected %0h, got %0h", exp_res.drive_phase,
               got.drive_phase);
        errors++;
      end
      if (got.error_estimate !== exp_res.error_estimate) begin
        $error("error_estimate: expected %0d, got %0d", exp_res.error_estimate,
               got.error_estimate);
        errors++;
      end
      if (got.saturated !== exp_res.saturated) begin
        $error("saturated: expected %0b, got %0b", exp_res.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  rkf45_scoreboard sb;
  int              send_idle;
  int              recv_idle;
  logic [31:0]     cfg_set [6];

  duffing_rkf45_step DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_o       (position_o),
    .velocity_o       (velocity_o),
    .drive_phase_o    (drive_phase_o),
    .error_estimate_o (error_estimate_o),
    .saturated_o      (saturated_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
  end

  // Outputs and stall only move at rising edges, so the value seen at the
  // falling edge is what the next rising edge takes.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({position_o, velocity_o, drive_phase_o, error_estimate_o,
                       saturated_o});
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    sb.note_config(idx, d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_all();
    drain();
    write_reg(REG_STEP, cfg_set[0]);
    write_reg(REG_DAMP, cfg_set[1]);
    write_reg(REG_FAMP, cfg_set[2]);
    write_reg(REG_PPS,  cfg_set[3]);
    write_reg(REG_IPOS, cfg_set[4]);
    write_reg(REG_IVEL, cfg_set[5]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic restart);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    sb.note_input(restart);
  endtask

  // Mostly a gently damped, stable oscillator; now and then any bit pattern.
  function automatic logic [31:0] pick_signed(int span_bits);
    if ($urandom_range(7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, (1 << span_bits) - 1)) - (1 << (span_bits - 1)));
  endfunction

  task automatic random_config();
    cfg_set[0] = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 1 << 22);
    cfg_set[1] = pick_signed(26);
    cfg_set[2] = pick_signed(26);
    cfg_set[3] = $urandom;
    cfg_set[4] = pick_signed(26);
    cfg_set[5] = pick_signed(26);
    load_all();
  endtask

  initial begin
    sb = new();
    send_idle = 0;
    recv_idle = 0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    restart_i   <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, plain steps and restarts.
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    // Zero step leaves the state in place; top bit of step_size is dropped.
    cfg_set = '{32'h0, DAMP_RST, FAMP_RST, PPS_RST, IPOS_RST, IVEL_RST};
    load_all();
    send_item(1'b0);
    send_item(1'b1);
    cfg_set = '{32'hFFFF_FFFF, DAMP_RST, FAMP_RST, PPS_RST, IPOS_RST, IVEL_RST};
    load_all();
    send_item(1'b1);
    send_item(1'b0);

    // Extremes of every register, both polarities.
    cfg_set = '{32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000};
    load_all();
    send_item(1'b1);
    send_item(1'b0);
    cfg_set = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                32'h8000_0000, 32'h7FFF_FFFF};
    load_all();
    send_item(1'b1);
    send_item(1'b0);

    // Unused register indexes must not disturb anything.
    drain();
    write_reg(3'd6, 32'hDEAD_BEEF);
    write_reg(3'd7, 32'h1234_5678);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);

    // Quarter and half turn phase steps land on the cosine fold boundaries.
    cfg_set = '{32'h0004_0000, DAMP_RST, 32'h0100_0000, 32'h4000_0000,
                IPOS_RST, IVEL_RST};
    load_all();
    repeat (4) send_item(1'b0);
    cfg_set[3] = 32'h8000_0000;
    load_all();
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);

    for (int blk = 0; blk < 13; blk++) begin
      if (blk < 4) begin
        send_idle = 34; recv_idle = 72;
      end else if (blk < 8) begin
        send_idle = 72; recv_idle = 34;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      random_config();
      for (int n = 0; n < 100; n++) begin
        send_item(n == 0 || $urandom_range(19) == 0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
